### rtl/core/s5p_pkg.sv
// ----------------------------------------------------------------------------
// s5p_pkg
// Shared types and constants for the SOCKS5 connect request parser.
// ----------------------------------------------------------------------------
package s5p_pkg;

    localparam int QUEUE_DEPTH = 4;

    // protocol byte values
    localparam logic [7:0] SOCKS_VERSION  = 8'd5;
    localparam logic [7:0] CONNECT_CODE   = 8'd1;
    localparam logic [7:0] ADDR_CODE_IP4  = 8'd1;
    localparam logic [7:0] ADDR_CODE_NAME = 8'd3;
    localparam logic [7:0] ADDR_CODE_IP6  = 8'd4;
    localparam logic [7:0] IPV4_LEN       = 8'd4;
    localparam logic [7:0] IPV6_LEN       = 8'd16;

    // reported address type codes
    localparam logic [1:0] AT_IPV4   = 2'd0;
    localparam logic [1:0] AT_DOMAIN = 2'd1;
    localparam logic [1:0] AT_IPV6   = 2'd2;

    // error codes
    localparam logic ERR_BAD_VERSION = 1'b0;
    localparam logic ERR_BAD_ATYP    = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADDR       = 2'd0,
        KIND_DONE       = 2'd1,
        KIND_ERROR      = 2'd2,
        KIND_INCOMPLETE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_VER   = 3'd0,
        PH_CMD   = 3'd1,
        PH_RSV   = 3'd2,
        PH_ATYP  = 3'd3,
        PH_ADDR  = 3'd4,
        PH_PORTH = 3'd5,
        PH_PORTL = 3'd6,
        PH_SKIP  = 3'd7
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  addr_byte;
        logic [7:0]  addr_index;
        logic [1:0]  addr_type;
        logic [7:0]  command;
        logic        is_connect;
        logic [15:0] port;
        logic [8:0]  consumed;
        logic        error_code;
    } t_result;

    // one queue entry: the byte's own result and/or a trailing incomplete
    typedef struct packed {
        logic    has_main;
        logic    has_inc;
        t_result main;
    } t_entry;

endpackage

### rtl/core/s5p_front.sv
// ----------------------------------------------------------------------------
// s5p_front
// Byte parser: tracks the request field, classifies each byte and builds
// the queue entry holding the results that byte causes.
// ----------------------------------------------------------------------------
module s5p_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_buffer_end,
    input  logic              i_full,
    output logic              o_in_ready,
    output logic              o_push,
    output s5p_pkg::t_entry   o_push_entry
);

    s5p_pkg::t_phase r_phase, n_phase, w_mid_phase;
    logic [8:0] r_pos, n_pos;
    logic [7:0] r_cmd, n_cmd;
    logic [1:0] r_atype, n_atype;
    logic [7:0] r_rem, n_rem;
    logic [7:0] r_count, n_count;
    logic [7:0] r_port_high, n_port_high;
    logic       w_accept;

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= s5p_pkg::PH_VER;
            r_pos       <= '0;
            r_cmd       <= '0;
            r_atype     <= '0;
            r_rem       <= '0;
            r_count     <= '0;
            r_port_high <= '0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_cmd       <= n_cmd;
            r_atype     <= n_atype;
            r_rem       <= n_rem;
            r_count     <= n_count;
            r_port_high <= n_port_high;
        end
    end

    // next state
    always_comb begin
        w_mid_phase = r_phase;
        n_pos       = r_pos;
        n_cmd       = r_cmd;
        n_atype     = r_atype;
        n_rem       = r_rem;
        n_count     = r_count;
        n_port_high = r_port_high;
        unique case (r_phase)
            s5p_pkg::PH_VER: begin
                if (i_data_byte != s5p_pkg::SOCKS_VERSION) begin
                    w_mid_phase = s5p_pkg::PH_SKIP;
                    n_pos       = '0;
                end else begin
                    w_mid_phase = s5p_pkg::PH_CMD;
                    n_pos       = 9'd1;
                end
            end
            s5p_pkg::PH_CMD: begin
                n_cmd       = i_data_byte;
                n_pos       = r_pos + 9'd1;
                w_mid_phase = s5p_pkg::PH_RSV;
            end
            s5p_pkg::PH_RSV: begin
                n_pos       = r_pos + 9'd1;
                w_mid_phase = s5p_pkg::PH_ATYP;
            end
            s5p_pkg::PH_ATYP: begin
                n_count     = '0;
                n_pos       = r_pos + 9'd1;
                w_mid_phase = s5p_pkg::PH_ADDR;
                unique case (i_data_byte)
                    s5p_pkg::ADDR_CODE_IP4: begin
                        n_atype = s5p_pkg::AT_IPV4;
                        n_rem   = s5p_pkg::IPV4_LEN;
                    end
                    s5p_pkg::ADDR_CODE_NAME: begin
                        n_atype = s5p_pkg::AT_DOMAIN;
                        n_rem   = '0;
                    end
                    s5p_pkg::ADDR_CODE_IP6: begin
                        n_atype = s5p_pkg::AT_IPV6;
                        n_rem   = s5p_pkg::IPV6_LEN;
                    end
                    default: begin
                        n_count     = r_count;
                        n_pos       = '0;
                        w_mid_phase = s5p_pkg::PH_SKIP;
                    end
                endcase
            end
            s5p_pkg::PH_ADDR: begin
                // domain: the length byte loads the remaining count
                if (r_atype == s5p_pkg::AT_DOMAIN && r_count == 8'd0) begin
                    n_rem = i_data_byte;
                end else if (r_rem != 8'd0) begin
                    n_rem = r_rem - 8'd1;
                end
                n_count = r_count + 8'd1;
                n_pos   = r_pos + 9'd1;
                if (n_rem == 8'd0) begin
                    w_mid_phase = s5p_pkg::PH_PORTH;
                end
            end
            s5p_pkg::PH_PORTH: begin
                n_port_high = i_data_byte;
                n_pos       = r_pos + 9'd1;
                w_mid_phase = s5p_pkg::PH_PORTL;
            end
            s5p_pkg::PH_PORTL: begin
                w_mid_phase = s5p_pkg::PH_VER;
                n_pos       = '0;
            end
            s5p_pkg::PH_SKIP: begin
                w_mid_phase = s5p_pkg::PH_SKIP;
            end
            default: begin
                w_mid_phase = s5p_pkg::PH_VER;
            end
        endcase

        n_phase = w_mid_phase;
        if (i_buffer_end) begin
            n_phase = s5p_pkg::PH_VER;
            n_pos   = '0;
        end

        if (!w_accept) begin
            n_phase     = r_phase;
            n_pos       = r_pos;
            n_cmd       = r_cmd;
            n_atype     = r_atype;
            n_rem       = r_rem;
            n_count     = r_count;
            n_port_high = r_port_high;
        end
    end

    // result entry for the byte on the input
    always_comb begin
        o_push_entry = '0;
        o_push_entry.main.kind = s5p_pkg::KIND_ADDR;
        unique case (r_phase)
            s5p_pkg::PH_VER: begin
                if (i_data_byte != s5p_pkg::SOCKS_VERSION) begin
                    o_push_entry.has_main        = 1'b1;
                    o_push_entry.main.kind       = s5p_pkg::KIND_ERROR;
                    o_push_entry.main.error_code = s5p_pkg::ERR_BAD_VERSION;
                end
            end
            s5p_pkg::PH_ATYP: begin
                if (i_data_byte != s5p_pkg::ADDR_CODE_IP4 &&
                    i_data_byte != s5p_pkg::ADDR_CODE_NAME &&
                    i_data_byte != s5p_pkg::ADDR_CODE_IP6) begin
                    o_push_entry.has_main        = 1'b1;
                    o_push_entry.main.kind       = s5p_pkg::KIND_ERROR;
                    o_push_entry.main.error_code = s5p_pkg::ERR_BAD_ATYP;
                end
            end
            s5p_pkg::PH_ADDR: begin
                o_push_entry.has_main        = 1'b1;
                o_push_entry.main.kind       = s5p_pkg::KIND_ADDR;
                o_push_entry.main.addr_byte  = i_data_byte;
                o_push_entry.main.addr_index = r_count;
                o_push_entry.main.addr_type  = r_atype;
            end
            s5p_pkg::PH_PORTL: begin
                o_push_entry.has_main        = 1'b1;
                o_push_entry.main.kind       = s5p_pkg::KIND_DONE;
                o_push_entry.main.addr_type  = r_atype;
                o_push_entry.main.command    = r_cmd;
                o_push_entry.main.is_connect = (r_cmd == s5p_pkg::CONNECT_CODE);
                o_push_entry.main.port       = {r_port_high, i_data_byte};
                o_push_entry.main.consumed   = r_pos + 9'd1;
            end
            default: begin
                o_push_entry.has_main = 1'b0;
            end
        endcase
        // buffer ran out with a request still open
        o_push_entry.has_inc = i_buffer_end &&
                               w_mid_phase != s5p_pkg::PH_VER &&
                               w_mid_phase != s5p_pkg::PH_SKIP;
    end

    assign o_push = w_accept && (o_push_entry.has_main || o_push_entry.has_inc);

endmodule

### rtl/core/s5p_queue.sv
// ----------------------------------------------------------------------------
// s5p_queue
// Small register queue of result entries between parser and output stage.
// ----------------------------------------------------------------------------
module s5p_queue #(
    parameter int P_DEPTH = s5p_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  s5p_pkg::t_entry   i_push_entry,
    input  logic              i_pop,
    output s5p_pkg::t_entry   o_head,
    output logic              o_full,
    output logic              o_empty
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    s5p_pkg::t_entry r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/core/s5p_back.sv
// ----------------------------------------------------------------------------
// s5p_back
// Output stage: serializes each queue entry into one or two result transfers.
// ----------------------------------------------------------------------------
module s5p_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  s5p_pkg::t_entry   i_head,
    input  logic              i_empty,
    input  logic              i_out_ready,
    output logic              o_pop,
    output logic              o_out_valid,
    output s5p_pkg::t_result  o_result,
    output logic              o_run_end
);

    logic r_inc_pending;
    logic w_send_inc;
    logic w_accept;

    assign o_out_valid = !i_empty;
    assign w_accept    = o_out_valid && i_out_ready;
    assign w_send_inc  = r_inc_pending || !i_head.has_main;

    always_comb begin
        if (w_send_inc) begin
            o_result      = '0;
            o_result.kind = s5p_pkg::KIND_INCOMPLETE;
            o_run_end     = 1'b1;
        end else begin
            o_result  = i_head.main;
            o_run_end = !i_head.has_inc;
        end
    end

    // the entry leaves once its last result is taken
    assign o_pop = w_accept && (w_send_inc || !i_head.has_inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inc_pending <= 1'b0;
        end else if (w_accept) begin
            r_inc_pending <= !w_send_inc && i_head.has_inc;
        end
    end

endmodule

### rtl/core/socks5_connect_request_parser_unit.sv
// ----------------------------------------------------------------------------
// socks5_connect_request_parser_unit
// SOCKS5 request parser: one byte per transfer in, address/done/error/
// incomplete results out, with a result queue between parser and output.
// ----------------------------------------------------------------------------
// queueing: a byte's result entry is registered in a queue of P_QUEUE_DEPTH entries
// throughput: one byte per cycle while the queue is not full; the output stage
//   gives one result per cycle while i_out_ready is high, so a byte with two
//   results (last byte of an open request) is sent as two, and the queue absorbs that
// reset: synchronous active-low, clears the parser phase and empties the queue
// ----------------------------------------------------------------------------
module socks5_connect_request_parser_unit #(
    parameter int P_QUEUE_DEPTH = s5p_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_addr_byte,
    output logic [7:0]  o_addr_index,
    output logic [1:0]  o_addr_type,
    output logic [7:0]  o_command,
    output logic        o_is_connect,
    output logic [15:0] o_port,
    output logic [8:0]  o_consumed,
    output logic        o_error_code,
    output logic        o_run_end
);

    s5p_pkg::t_entry  w_push_entry, w_head;
    s5p_pkg::t_result w_result;
    logic             w_push, w_pop, w_full, w_empty;

    s5p_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_data_byte  (i_data_byte),
        .i_buffer_end (i_buffer_end),
        .i_full       (w_full),
        .o_in_ready   (o_in_ready),
        .o_push       (w_push),
        .o_push_entry (w_push_entry)
    );

    s5p_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_entry (w_push_entry),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_full       (w_full),
        .o_empty      (w_empty)
    );

    s5p_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_empty     (w_empty),
        .i_out_ready (i_out_ready),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_result    (w_result),
        .o_run_end   (o_run_end)
    );

    assign o_kind       = w_result.kind;
    assign o_addr_byte  = w_result.addr_byte;
    assign o_addr_index = w_result.addr_index;
    assign o_addr_type  = w_result.addr_type;
    assign o_command    = w_result.command;
    assign o_is_connect = w_result.is_connect;
    assign o_port       = w_result.port;
    assign o_consumed   = w_result.consumed;
    assign o_error_code = w_result.error_code;

endmodule

### rtl/core/s5p_checker.sv
// ----------------------------------------------------------------------------
// s5p_checker
// Port-level checks for the SOCKS5 request parser, bound to the top level.
// ----------------------------------------------------------------------------
module s5p_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_command,
    input logic        o_is_connect,
    input logic        o_run_end
);

    // an offered result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind) && $stable(o_run_end))
        else $error("output result changed while stalled");

    // reset empties the queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

    // only an address byte can be followed by another result of the same byte
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != s5p_pkg::KIND_ADDR |-> o_run_end)
        else $error("non-address result without run end");

    // an open run is closed by an incomplete result
    a_run_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_run_end |=>
            o_out_valid && o_kind == s5p_pkg::KIND_INCOMPLETE)
        else $error("open run not followed by incomplete result");

    a_connect_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == s5p_pkg::KIND_DONE |->
            o_is_connect == (o_command == s5p_pkg::CONNECT_CODE))
        else $error("connect flag does not match command");

endmodule

bind socks5_connect_request_parser_unit s5p_checker u_s5p_checker (.*);

### tb/socks5_connect_request_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// socks5_connect_request_parser_unit_tb
// Drives SOCKS5 request buffers byte by byte through the parser: a short table
// of directed bytes, then random requests (mostly well formed, some truncated,
// some with bad version or address type, some noise). Every result transfer is
// checked field by field against an in-bench model or a typed-in expectation, with
// random gaps on both handshakes, two long output stalls and a full drain mid-run.
// ----------------------------------------------------------------------------
module socks5_connect_request_parser_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        s5p_pkg::t_result res;
        logic             run_end;
    } t_parse_out;

    typedef struct packed {
        logic [7:0]     data;
        logic           last;
        logic           fixed;   // expectation typed in below, not predicted
        logic           has_out;
        s5p_pkg::t_kind kind;
        logic           code;
    } t_byte_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_buffer_end = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_addr_byte;
    logic [7:0]  o_addr_index;
    logic [1:0]  o_addr_type;
    logic [7:0]  o_command;
    logic        o_is_connect;
    logic [15:0] o_port;
    logic [8:0]  o_consumed;
    logic        o_error_code;
    logic        o_run_end;

    socks5_connect_request_parser_unit dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // parser model state
    s5p_pkg::t_phase st_phase = s5p_pkg::PH_VER;
    logic [8:0] st_pos = '0;
    logic [7:0] st_cmd = '0;
    logic [1:0] st_atype = '0;
    logic [7:0] st_remaining = '0;
    logic [7:0] st_count = '0;
    logic [7:0] st_port_hi = '0;

    t_parse_out byte_results[$];
    t_parse_out pending_parse_results[$];

    int  error_count = 0;
    int  bytes_sent = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    bit  tx_quiet = 1'b0;
    bit  rx_quiet = 1'b0;

    t_byte_row directed_rows [25];

    function automatic s5p_pkg::t_result blank_result(input s5p_pkg::t_kind kind);
        s5p_pkg::t_result r;
        r = '0;
        r.kind = kind;
        return r;
    endfunction

    function automatic void add_byte_result(input s5p_pkg::t_result r);
        t_parse_out o;
        o.res = r;
        o.run_end = 1'b0;
        byte_results.insert(byte_results.size(), o);
    endfunction

    // advances the model by one byte, leaves its results in byte_results
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        s5p_pkg::t_result r;
        t_parse_out       tail;
        logic             bad_type;
        byte_results.delete();
        case (st_phase)
            s5p_pkg::PH_VER: begin
                if (b != s5p_pkg::SOCKS_VERSION) begin
                    r = blank_result(s5p_pkg::KIND_ERROR);
                    r.error_code = s5p_pkg::ERR_BAD_VERSION;
                    add_byte_result(r);
                    st_phase = s5p_pkg::PH_SKIP;
                    st_pos = '0;
                end else begin
                    st_pos = 9'd1;
                    st_phase = s5p_pkg::PH_CMD;
                end
            end
            s5p_pkg::PH_CMD: begin
                st_cmd = b;
                st_pos = st_pos + 9'd1;
                st_phase = s5p_pkg::PH_RSV;
            end
            s5p_pkg::PH_RSV: begin
                st_pos = st_pos + 9'd1;
                st_phase = s5p_pkg::PH_ATYP;
            end
            s5p_pkg::PH_ATYP: begin
                bad_type = 1'b0;
                if (b == s5p_pkg::ADDR_CODE_IP4) begin
                    st_atype = s5p_pkg::AT_IPV4;
                    st_remaining = s5p_pkg::IPV4_LEN;
                end else if (b == s5p_pkg::ADDR_CODE_NAME) begin
                    st_atype = s5p_pkg::AT_DOMAIN;
                    st_remaining = '0;
                end else if (b == s5p_pkg::ADDR_CODE_IP6) begin
                    st_atype = s5p_pkg::AT_IPV6;
                    st_remaining = s5p_pkg::IPV6_LEN;
                end else begin
                    bad_type = 1'b1;
                end
                if (bad_type) begin
                    r = blank_result(s5p_pkg::KIND_ERROR);
                    r.error_code = s5p_pkg::ERR_BAD_ATYP;
                    add_byte_result(r);
                    st_phase = s5p_pkg::PH_SKIP;
                    st_pos = '0;
                end else begin
                    st_count = '0;
                    st_pos = st_pos + 9'd1;
                    st_phase = s5p_pkg::PH_ADDR;
                end
            end
            s5p_pkg::PH_ADDR: begin
                r = blank_result(s5p_pkg::KIND_ADDR);
                r.addr_byte = b;
                r.addr_index = st_count;
                r.addr_type = st_atype;
                add_byte_result(r);
                // first domain byte is the name length
                if (st_atype == s5p_pkg::AT_DOMAIN && st_count == 8'd0) begin
                    st_remaining = b;
                end else if (st_remaining != 8'd0) begin
                    st_remaining = st_remaining - 8'd1;
                end
                st_count = st_count + 8'd1;
                st_pos = st_pos + 9'd1;
                if (st_remaining == 8'd0) begin
                    st_phase = s5p_pkg::PH_PORTH;
                end
            end
            s5p_pkg::PH_PORTH: begin
                st_port_hi = b;
                st_pos = st_pos + 9'd1;
                st_phase = s5p_pkg::PH_PORTL;
            end
            s5p_pkg::PH_PORTL: begin
                r = blank_result(s5p_pkg::KIND_DONE);
                r.addr_type = st_atype;
                r.command = st_cmd;
                r.is_connect = (st_cmd == s5p_pkg::CONNECT_CODE);
                r.port = {st_port_hi, b};
                r.consumed = st_pos + 9'd1;
                add_byte_result(r);
                st_phase = s5p_pkg::PH_VER;
                st_pos = '0;
            end
            default: begin
            end
        endcase
        if (last) begin
            if (st_phase != s5p_pkg::PH_VER && st_phase != s5p_pkg::PH_SKIP) begin
                add_byte_result(blank_result(s5p_pkg::KIND_INCOMPLETE));
            end
            st_phase = s5p_pkg::PH_VER;
            st_pos = '0;
        end
        if (byte_results.size() > 0) begin
            tail = byte_results[byte_results.size() - 1];
            tail.run_end = 1'b1;
            byte_results[byte_results.size() - 1] = tail;
        end
    endfunction

    // returns at the rising edge where the byte is transferred
    task automatic drive_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_data_byte <= d;
        i_buffer_end <= last;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic send_predicted(input logic [7:0] d, input logic last);
        drive_byte(d, last);
        parse_byte(d, last);
        foreach (byte_results[k]) begin
            pending_parse_results.insert(pending_parse_results.size(), byte_results[k]);
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_parse_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_random_buffer();
        logic [7:0] bytes[$];
        logic [7:0] v;
        int         n_req;
        int         sel;
        int         len;
        int         cut;
        bit         mark_last;
        tx_quiet = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 19) == 0) begin
            // noise: loose bytes with random end marks
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                send_predicted(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            return;
        end
        n_req = $urandom_range(1, 3);
        for (int q = 0; q < n_req; q++) begin
            if ($urandom_range(0, 19) == 0) begin
                do v = 8'($urandom_range(0, 255)); while (v == s5p_pkg::SOCKS_VERSION);
            end else begin
                v = s5p_pkg::SOCKS_VERSION;
            end
            bytes.insert(bytes.size(), v);
            bytes.insert(bytes.size(), $urandom_range(0, 1) ? s5p_pkg::CONNECT_CODE
                                                            : 8'($urandom_range(0, 255)));
            bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                bytes.insert(bytes.size(), s5p_pkg::ADDR_CODE_IP4);
                repeat (4) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            end else if (sel < 65) begin
                bytes.insert(bytes.size(), s5p_pkg::ADDR_CODE_NAME);
                if ($urandom_range(0, 29) == 0) begin
                    len = $urandom_range(0, 2) == 0 ? 255 : int'($urandom_range(200, 255));
                end else begin
                    len = $urandom_range(0, 12);
                end
                bytes.insert(bytes.size(), 8'(len));
                repeat (len) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            end else if (sel < 92) begin
                bytes.insert(bytes.size(), s5p_pkg::ADDR_CODE_IP6);
                repeat (16) bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            end else begin
                bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                repeat ($urandom_range(0, 4)) begin
                    bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
                end
            end
            bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
            bytes.insert(bytes.size(), 8'($urandom_range(0, 255)));
        end
        // truncation: the buffer may end inside a request
        if ($urandom_range(0, 6) == 0) begin
            cut = $urandom_range(1, bytes.size());
            while (bytes.size() > cut) void'(bytes.pop_back());
        end
        mark_last = ($urandom_range(0, 6) != 0);
        foreach (bytes[k]) begin
            send_predicted(bytes[k], mark_last && (k == bytes.size() - 1));
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] expv,
                               input logic [15:0] actv);
        if (expv !== actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            error_count++;
        end
    endtask

    // result side: random stalls, two long hold-offs
    initial begin
        int         stall;
        t_parse_out e;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (results_seen == 200 || results_seen == 1200) begin
                stall = HOLD_CYCLES;
            end else begin
                stall = rx_quiet ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            results_seen++;
            if (results_seen % 64 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
            if (pending_parse_results.size() == 0) begin
                $error("result transfer with nothing expected: kind %0d", o_kind);
                error_count++;
            end else begin
                e = pending_parse_results.pop_front();
                check_field("kind", 16'(e.res.kind), 16'(o_kind));
                check_field("addr_byte", 16'(e.res.addr_byte), 16'(o_addr_byte));
                check_field("addr_index", 16'(e.res.addr_index), 16'(o_addr_index));
                check_field("addr_type", 16'(e.res.addr_type), 16'(o_addr_type));
                check_field("command", 16'(e.res.command), 16'(o_command));
                check_field("is_connect", 16'(e.res.is_connect), 16'(o_is_connect));
                check_field("port", e.res.port, o_port);
                check_field("consumed", 16'(e.res.consumed), 16'(o_consumed));
                check_field("error_code", 16'(e.res.error_code), 16'(o_error_code));
                check_field("run_end", 16'(e.run_end), 16'(o_run_end));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[socks5_connect_request_parser_unit] ERROR");
            $finish;
        end
    end

    initial begin
        t_parse_out fixed_out;
        bit         mid_drained;
        mid_drained = 1'b0;
        directed_rows = '{
            // bad version, skip to buffer end, version alone at buffer end
            '{8'h00, 1'b0, 1'b1, 1'b1, s5p_pkg::KIND_ERROR,      s5p_pkg::ERR_BAD_VERSION},
            '{8'hFF, 1'b1, 1'b1, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h05, 1'b1, 1'b1, 1'b1, s5p_pkg::KIND_INCOMPLETE, 1'b0},
            // ipv4 connect, reserved all ones, port 65535
            '{8'h05, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h01, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h01, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h00, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h80, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h7F, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            // unknown address type, ends the buffer
            '{8'h05, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'hFF, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h00, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h00, 1'b1, 1'b1, 1'b1, s5p_pkg::KIND_ERROR,      s5p_pkg::ERR_BAD_ATYP},
            // empty domain name, command 0, port 0
            '{8'h05, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h00, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h00, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h03, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h00, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h00, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            '{8'h00, 1'b0, 1'b0, 1'b0, s5p_pkg::KIND_ADDR,       1'b0},
            // new request in the same buffer, cut short at once
            '{8'h05, 1'b1, 1'b1, 1'b1, s5p_pkg::KIND_INCOMPLETE, 1'b0}
        };

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].fixed) begin
                drive_byte(directed_rows[k].data, directed_rows[k].last);
                parse_byte(directed_rows[k].data, directed_rows[k].last);
                if (directed_rows[k].has_out) begin
                    fixed_out.res = blank_result(directed_rows[k].kind);
                    fixed_out.res.error_code = directed_rows[k].code;
                    fixed_out.run_end = 1'b1;
                    pending_parse_results.insert(pending_parse_results.size(), fixed_out);
                end
            end else begin
                send_predicted(directed_rows[k].data, directed_rows[k].last);
            end
        end
        wait_for_results();

        bytes_sent = 0;
        while (bytes_sent < RANDOM_ITEMS) begin
            send_random_buffer();
            if (!mid_drained && bytes_sent >= RANDOM_ITEMS / 2) begin
                wait_for_results();
                mid_drained = 1'b1;
            end
        end
        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (error_count == 0) begin
            $display("[socks5_connect_request_parser_unit] OK");
        end else begin
            $display("[socks5_connect_request_parser_unit] ERROR");
        end
        $finish;
    end

endmodule
